// ===== hdl/rwls_pkg.sv =====
`default_nettype none

package rwls_pkg;

   // Field widths
   localparam int LevelW  = 8;
   localparam int DrawW   = 6;
   localparam int PosW    = 5;
   localparam int PeriodW = 16;
   localparam int AmountW = 11;

   // Configuration port
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;
   localparam logic [CsrIndexW-1:0] CsrPeriod = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrAmount = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrLocked = 2'd2;

   // Register reset values
   localparam logic [PeriodW-1:0] PeriodReset = 16'd64;
   localparam logic [AmountW-1:0] AmountReset = 11'd0;

   // Random walk step: head + draw - offset, clamped to the level range
   localparam logic [LevelW:0] DrawOffset = 9'd31;
   localparam logic [LevelW:0] LevelMax   = 9'd255;

   // Smoothing interval divisor, 2^AmountW - 1
   localparam logic [AmountW:0] AmountFull = 12'd2047;
   localparam int ProductW = AmountW + PeriodW;

   // Smoothing history
   localparam int HistLen  = 32;
   localparam int HistLog2 = 5;
   localparam int SumW     = LevelW + HistLog2;

   // Cycles the interval pipeline needs after a register write
   localparam int SettleW = 2;
   localparam logic [SettleW-1:0] CfgSettleCycles = 2'd2;

   // Per-tick control from the counters
   typedef struct packed {
      logic advance;
      logic push;
   } tick_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/rwls_interval.sv =====
`default_nettype none

// Smoothing interval = amount * period / 2047, two register stages.
module rwls_interval (
   input  wire                             clock,
   input  wire                             reset,
   input  wire  [rwls_pkg::PeriodW-1:0]    period,
   input  wire  [rwls_pkg::AmountW-1:0]    amount,
   output logic [rwls_pkg::PeriodW-1:0]    interval
);

   logic [rwls_pkg::ProductW-1:0] product_ff;
   logic [rwls_pkg::ProductW-1:0] product_in;
   logic [rwls_pkg::PeriodW-1:0]  interval_ff;
   logic [rwls_pkg::PeriodW-1:0]  interval_in;

   logic [rwls_pkg::PeriodW-1:0]  q0;
   logic [rwls_pkg::PeriodW:0]    r0;
   logic [5:0]                    q1;
   logic [rwls_pkg::AmountW:0]    r1;
   logic                          corr;

   assign product_in = rwls_pkg::ProductW'(amount) * rwls_pkg::ProductW'(period);

   // Divide by 2^11-1: fold the high part back into the remainder twice
   always_comb begin
      q0   = product_ff[rwls_pkg::ProductW-1:rwls_pkg::AmountW];
      r0   = (rwls_pkg::PeriodW+1)'(product_ff[rwls_pkg::AmountW-1:0])
             + (rwls_pkg::PeriodW+1)'(q0);
      q1   = r0[rwls_pkg::PeriodW:rwls_pkg::AmountW];
      r1   = (rwls_pkg::AmountW+1)'(r0[rwls_pkg::AmountW-1:0])
             + (rwls_pkg::AmountW+1)'(q1);
      corr = r1 >= rwls_pkg::AmountFull;
      interval_in = q0 + rwls_pkg::PeriodW'(q1) + rwls_pkg::PeriodW'(corr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         product_ff  <= '0;
         interval_ff <= '0;
      end else begin
         product_ff  <= product_in;
         interval_ff <= interval_in;
      end
   end

   assign interval = interval_ff;

endmodule

`default_nettype wire

// ===== hdl/rwls_tick.sv =====
`default_nettype none

// Tick counters and step position.
module rwls_tick #(
   parameter int LOOP_LENGTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 take,
   input  wire  [rwls_pkg::PeriodW-1:0]        period,
   input  wire  [rwls_pkg::PeriodW-1:0]        interval,
   output rwls_pkg::tick_ctl_type              ctl,
   output logic [$clog2(LOOP_LENGTH)-1:0]      step_index_in
);

   localparam int IdxW = $clog2(LOOP_LENGTH);

   logic [rwls_pkg::PeriodW-1:0] tick_count_ff;
   logic [rwls_pkg::PeriodW-1:0] smooth_count_ff;
   logic [IdxW-1:0]              step_index_ff;
   logic [rwls_pkg::PeriodW-1:0] tick_inc;
   logic [rwls_pkg::PeriodW-1:0] smooth_inc;

   // Advance when the counter reaches the period; push when it reaches the interval
   always_comb begin
      tick_inc    = tick_count_ff + 1'b1;
      smooth_inc  = smooth_count_ff + 1'b1;
      ctl.advance = tick_inc >= period;
      ctl.push    = smooth_inc >= interval;
      if (!ctl.advance) begin
         step_index_in = step_index_ff;
      end else if (step_index_ff == IdxW'(LOOP_LENGTH - 1)) begin
         step_index_in = '0;
      end else begin
         step_index_in = step_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         smooth_count_ff <= '0;
         step_index_ff   <= '0;
      end else if (take) begin
         tick_count_ff   <= ctl.advance ? '0 : tick_inc;
         smooth_count_ff <= ctl.push ? '0 : smooth_inc;
         step_index_ff   <= step_index_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rwls_ring.sv =====
`default_nettype none

// Loop ring: rotate, or shift in a new random walk head.
module rwls_ring #(
   parameter int LOOP_LENGTH = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             take,
   input  rwls_pkg::tick_ctl_type          ctl,
   input  wire                             locked,
   input  wire  [rwls_pkg::DrawW-1:0]      draw,
   output logic [rwls_pkg::LevelW-1:0]     head_next
);

   logic [rwls_pkg::LevelW-1:0] ring_ff [LOOP_LENGTH];
   logic [rwls_pkg::LevelW-1:0] head_in;
   logic [rwls_pkg::LevelW:0]   walk_sum;
   logic [rwls_pkg::LevelW:0]   walk_val;

   // New head: previous head plus draw minus offset, clamped, or the last entry if locked
   always_comb begin
      walk_sum = (rwls_pkg::LevelW+1)'(ring_ff[0]) + (rwls_pkg::LevelW+1)'(draw);
      walk_val = walk_sum - rwls_pkg::DrawOffset;
      if (locked) begin
         head_in = ring_ff[LOOP_LENGTH-1];
      end else if (walk_sum < rwls_pkg::DrawOffset) begin
         head_in = '0;
      end else if (walk_val > rwls_pkg::LevelMax) begin
         head_in = rwls_pkg::LevelMax[rwls_pkg::LevelW-1:0];
      end else begin
         head_in = walk_val[rwls_pkg::LevelW-1:0];
      end
      head_next = ctl.advance ? head_in : ring_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOOP_LENGTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (take && ctl.advance) begin
         ring_ff[0] <= head_in;
         for (int i = 1; i < LOOP_LENGTH; i++) begin
            ring_ff[i] <= ring_ff[i-1];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rwls_smooth.sv =====
`default_nettype none

// Smoothing history with a running sum; mean is the sum over 32.
module rwls_smooth (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             take,
   input  rwls_pkg::tick_ctl_type          ctl,
   input  wire  [rwls_pkg::LevelW-1:0]     head_next,
   output logic [rwls_pkg::LevelW-1:0]     mean_next
);

   logic [rwls_pkg::LevelW-1:0] hist_ff [rwls_pkg::HistLen];
   logic [rwls_pkg::SumW-1:0]   sum_ff;
   logic [rwls_pkg::SumW-1:0]   sum_in;

   // Drop the oldest entry, add the new head
   always_comb begin
      if (ctl.push) begin
         sum_in = sum_ff - rwls_pkg::SumW'(hist_ff[rwls_pkg::HistLen-1])
                  + rwls_pkg::SumW'(head_next);
      end else begin
         sum_in = sum_ff;
      end
      mean_next = sum_in[rwls_pkg::SumW-1:rwls_pkg::HistLog2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < rwls_pkg::HistLen; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (take && ctl.push) begin
         sum_ff     <= sum_in;
         hist_ff[0] <= head_next;
         for (int i = 1; i < rwls_pkg::HistLen; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/random_walk_loop_sequencer.sv =====
`default_nettype none

// Random walk loop sequencer. Each req transaction is one clock tick with a
// random draw; each tick returns exactly one rsp transaction with the level,
// the step position and whether the step advanced. One transaction is taken
// per cycle while the rsp register is free or drained and no csr write is
// settling. A csr write holds req_ready low while the multiply/divide
// pipeline recomputes the smoothing interval. csr_ready is always high;
// writes are meant for idle periods only.
module random_walk_loop_sequencer #(
   parameter int LOOP_LENGTH = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   // input ticks
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [rwls_pkg::DrawW-1:0]         req_random_draw,
   // results
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [rwls_pkg::LevelW-1:0]        rsp_level,
   output logic [rwls_pkg::PosW-1:0]          rsp_step_position,
   output logic                               rsp_step_advanced,
   // configuration
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [rwls_pkg::CsrIndexW-1:0]     csr_index,
   input  wire  [rwls_pkg::CsrDataW-1:0]      csr_wdata
);

   localparam int IdxW = $clog2(LOOP_LENGTH);

   logic [rwls_pkg::PeriodW-1:0] period_ff;
   logic [rwls_pkg::AmountW-1:0] amount_ff;
   logic                         locked_ff;
   logic [rwls_pkg::SettleW-1:0] settle_ff;

   logic                         rsp_valid_ff;
   logic [rwls_pkg::LevelW-1:0]  rsp_level_ff;
   logic [rwls_pkg::LevelW-1:0]  rsp_level_in;
   logic [rwls_pkg::PosW-1:0]    rsp_pos_ff;
   logic                         rsp_adv_ff;

   logic                         take;
   logic                         csr_take;
   logic [rwls_pkg::PeriodW-1:0] interval;
   rwls_pkg::tick_ctl_type       ctl;
   logic [IdxW-1:0]              step_index_in;
   logic [IdxW+4:0]              step_index_ext;
   logic [rwls_pkg::LevelW-1:0]  head_next;
   logic [rwls_pkg::LevelW-1:0]  mean_next;

   // Handshakes
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign req_ready = (!rsp_valid_ff || rsp_ready) && (settle_ff == '0);
   assign take      = req_valid && req_ready;

   // Configuration registers; hold input while the interval settles
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= rwls_pkg::PeriodReset;
         amount_ff <= rwls_pkg::AmountReset;
         locked_ff <= 1'b0;
         settle_ff <= '0;
      end else begin
         if (csr_take) begin
            settle_ff <= rwls_pkg::CfgSettleCycles;
            unique case (csr_index)
               rwls_pkg::CsrPeriod: period_ff <= csr_wdata[rwls_pkg::PeriodW-1:0];
               rwls_pkg::CsrAmount: amount_ff <= csr_wdata[rwls_pkg::AmountW-1:0];
               rwls_pkg::CsrLocked: locked_ff <= csr_wdata[0];
               default: ;
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
      end
   end

   rwls_interval u_interval (
      .clock    (clock),
      .reset    (reset),
      .period   (period_ff),
      .amount   (amount_ff),
      .interval (interval)
   );

   rwls_tick #(.LOOP_LENGTH(LOOP_LENGTH)) u_tick (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .period        (period_ff),
      .interval      (interval),
      .ctl           (ctl),
      .step_index_in (step_index_in)
   );

   rwls_ring #(.LOOP_LENGTH(LOOP_LENGTH)) u_ring (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .ctl       (ctl),
      .locked    (locked_ff),
      .draw      (req_random_draw),
      .head_next (head_next)
   );

   rwls_smooth u_smooth (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .ctl       (ctl),
      .head_next (head_next),
      .mean_next (mean_next)
   );

   // Select the level and report the low bits of the step index
   assign rsp_level_in   = (amount_ff == '0) ? head_next : mean_next;
   assign step_index_ext = {5'b0, step_index_in};

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_level_ff <= rsp_level_in;
         rsp_pos_ff   <= step_index_ext[rwls_pkg::PosW-1:0];
         rsp_adv_ff   <= ctl.advance;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level         = rsp_level_ff;
   assign rsp_step_position = rsp_pos_ff;
   assign rsp_step_advanced = rsp_adv_ff;

endmodule

`default_nettype wire

// ===== hdl/rwls_checker.sv =====
`default_nettype none

module rwls_checker #(
   parameter int LOOP_LENGTH = 32
) (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_ready,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire [rwls_pkg::LevelW-1:0]      rsp_level,
   input wire [rwls_pkg::PosW-1:0]        rsp_step_position,
   input wire                             rsp_step_advanced,
   input wire                             csr_valid,
   input wire                             csr_ready
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
         && $stable(rsp_step_position) && $stable(rsp_step_advanced))
      else $error("stalled rsp transaction changed");

   // Every accepted tick shows a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no rsp transaction");

   // A register write holds off input while the interval settles
   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready ##1 !req_ready)
      else $error("req accepted while interval settles");

   // Step position stays inside the loop
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (LOOP_LENGTH >= 32) || (32'(rsp_step_position) < LOOP_LENGTH))
      else $error("step position beyond loop length");

   // No result is offered in the first cycle out of reset
   a_first_pos: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp valid straight out of reset");

endmodule

bind random_walk_loop_sequencer rwls_checker #(.LOOP_LENGTH(LOOP_LENGTH)) u_rwls_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_level         (rsp_level),
   .rsp_step_position (rsp_step_position),
   .rsp_step_advanced (rsp_step_advanced),
   .csr_valid         (csr_valid),
   .csr_ready         (csr_ready)
);

`default_nettype wire

// ===== bench/random_walk_loop_sequencer_tb.sv =====
`default_nettype none

module random_walk_loop_sequencer_tb;

   localparam int RingLen = 32;
   localparam int WalkOffset = 31;
   localparam int LevelCeil = 255;
   localparam logic [31:0] AmountDiv = 32'd2047;
   localparam logic [rwls_pkg::CsrIndexW-1:0] CsrUnused = 2'd3;
   localparam int DrainSettle = 4;
   localparam int LongHoldoff = 200;

   typedef enum logic [1:0] {
      PLAN_TICK,
      PLAN_WRITE,
      PLAN_DRAIN
   } plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic [rwls_pkg::DrawW-1:0] draw;
      logic [rwls_pkg::CsrIndexW-1:0] index;
      logic [rwls_pkg::CsrDataW-1:0] data;
   } plan_item_type;

   typedef struct packed {
      logic [rwls_pkg::LevelW-1:0] level;
      logic [rwls_pkg::PosW-1:0] position;
      logic advanced;
   } walk_out_type;

   logic clock;
   logic reset;
   logic req_valid;
   wire req_ready;
   logic [rwls_pkg::DrawW-1:0] req_random_draw;
   wire rsp_valid;
   logic rsp_ready;
   wire [rwls_pkg::LevelW-1:0] rsp_level;
   wire [rwls_pkg::PosW-1:0] rsp_step_position;
   wire rsp_step_advanced;
   logic csr_valid;
   wire csr_ready;
   logic [rwls_pkg::CsrIndexW-1:0] csr_index;
   logic [rwls_pkg::CsrDataW-1:0] csr_wdata;

   // Sequencer state mirror and register copies
   logic [rwls_pkg::LevelW-1:0] ring_steps [RingLen];
   logic [rwls_pkg::LevelW-1:0] level_history [rwls_pkg::HistLen];
   logic [rwls_pkg::PeriodW-1:0] tick_ctr;
   logic [rwls_pkg::PeriodW-1:0] hist_ctr;
   int step_idx;
   logic [rwls_pkg::PeriodW-1:0] cfg_period;
   logic [rwls_pkg::AmountW-1:0] cfg_amount;
   logic cfg_locked;

   plan_item_type tick_plan [$];
   walk_out_type walk_results [$];

   logic req_taken;
   logic csr_taken;
   int gap_left;
   int settle_left;
   int stall_left;
   int holdoff_left;
   int next_holdoff_at;
   int results_taken;
   int bad_results;
   logic steady;
   int steady_left;

   random_walk_loop_sequencer #(
      .LOOP_LENGTH(RingLen)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_random_draw(req_random_draw),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_level(rsp_level),
      .rsp_step_position(rsp_step_position),
      .rsp_step_advanced(rsp_step_advanced),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the mirrored sequencer by one tick and return the resulting output
   function automatic walk_out_type walk_tick(input logic [rwls_pkg::DrawW-1:0] draw);
      int i;
      int walk_val;
      logic [rwls_pkg::LevelW-1:0] last;
      logic [31:0] interval;
      logic [rwls_pkg::SumW-1:0] hist_sum;
      walk_out_type res;
      res.advanced = 1'b0;
      tick_ctr = tick_ctr + 16'd1;
      if (tick_ctr >= cfg_period) begin
         tick_ctr = '0;
         res.advanced = 1'b1;
         if (step_idx < RingLen - 1) begin
            step_idx = step_idx + 1;
         end else begin
            step_idx = 0;
         end
         last = ring_steps[RingLen-1];
         for (i = RingLen - 1; i > 0; i--) begin
            ring_steps[i] = ring_steps[i-1];
         end
         ring_steps[0] = last;
         // Unlocked: new head is old head plus draw minus offset, clamped
         if (!cfg_locked) begin
            walk_val = int'(draw) - WalkOffset + int'(ring_steps[1]);
            if (walk_val > LevelCeil) begin
               walk_val = LevelCeil;
            end
            if (walk_val < 0) begin
               walk_val = 0;
            end
            ring_steps[0] = rwls_pkg::LevelW'(walk_val);
         end
      end
      // Copy the head into the history once per smoothing interval
      hist_ctr = hist_ctr + 16'd1;
      interval = (32'(cfg_amount) * 32'(cfg_period)) / AmountDiv;
      if (hist_ctr >= interval[15:0]) begin
         hist_ctr = '0;
         for (i = rwls_pkg::HistLen - 1; i > 0; i--) begin
            level_history[i] = level_history[i-1];
         end
         level_history[0] = ring_steps[0];
      end
      hist_sum = '0;
      for (i = 0; i < rwls_pkg::HistLen; i++) begin
         hist_sum = hist_sum + rwls_pkg::SumW'(level_history[i]);
      end
      res.level = (cfg_amount == '0) ? ring_steps[0]
                                     : hist_sum[rwls_pkg::SumW-1:rwls_pkg::HistLog2];
      res.position = rwls_pkg::PosW'(step_idx);
      return res;
   endfunction

   // Idle length: mostly short, a few long, none during steady stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) begin
         return 0;
      end
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   task automatic plan_tick(input logic [rwls_pkg::DrawW-1:0] draw);
      plan_item_type item;
      item.kind = PLAN_TICK;
      item.draw = draw;
      item.index = '0;
      item.data = '0;
      tick_plan.push_back(item);
   endtask

   task automatic plan_write(input logic [rwls_pkg::CsrIndexW-1:0] index,
                             input logic [rwls_pkg::CsrDataW-1:0] data);
      plan_item_type item;
      item.kind = PLAN_WRITE;
      item.draw = '0;
      item.index = index;
      item.data = data;
      tick_plan.push_back(item);
   endtask

   // Drain the block, then rewrite all registers; upper data bits carry junk
   task automatic plan_setup(input logic [rwls_pkg::PeriodW-1:0] period,
                             input logic [rwls_pkg::AmountW-1:0] amount,
                             input logic locked);
      plan_item_type item;
      item.kind = PLAN_DRAIN;
      item.draw = '0;
      item.index = '0;
      item.data = '0;
      tick_plan.push_back(item);
      plan_write(rwls_pkg::CsrPeriod, period);
      plan_write(rwls_pkg::CsrAmount, {5'($urandom), amount});
      plan_write(rwls_pkg::CsrLocked, {15'($urandom), locked});
      if ($urandom_range(0, 2) == 0) begin
         plan_write(CsrUnused, 16'($urandom));
      end
   endtask

   // Drive req and csr channels from the plan queue
   always @(negedge clock) begin : drive_req
      plan_item_type item;
      logic nv;
      logic ncv;
      logic [rwls_pkg::DrawW-1:0] nd;
      logic [rwls_pkg::CsrIndexW-1:0] ni;
      logic [rwls_pkg::CsrDataW-1:0] nw;
      if (!reset) begin
         nv = req_valid;
         ncv = csr_valid;
         nd = req_random_draw;
         ni = csr_index;
         nw = csr_wdata;
         if (req_taken) begin
            nv = 1'b0;
         end
         if (csr_taken) begin
            ncv = 1'b0;
         end
         if (!nv && !ncv) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (tick_plan.size() != 0) begin
               item = tick_plan[0];
               case (item.kind)
                  PLAN_TICK: begin
                     void'(tick_plan.pop_front());
                     nv = 1'b1;
                     nd = item.draw;
                     gap_left = pick_gap();
                     if (steady_left != 0) begin
                        steady_left--;
                     end else begin
                        steady = !steady;
                        steady_left = $urandom_range(30, 120);
                     end
                  end
                  PLAN_WRITE: begin
                     void'(tick_plan.pop_front());
                     ncv = 1'b1;
                     ni = item.index;
                     nw = item.data;
                  end
                  default: begin
                     // Hold until every result is back, then let the block settle
                     if (walk_results.size() != 0) begin
                        settle_left = DrainSettle;
                     end else if (settle_left != 0) begin
                        settle_left--;
                     end else begin
                        void'(tick_plan.pop_front());
                        settle_left = DrainSettle;
                     end
                  end
               endcase
            end
         end
         req_valid <= nv;
         req_random_draw <= nd;
         csr_valid <= ncv;
         csr_index <= ni;
         csr_wdata <= nw;
      end
   end

   // Drive rsp_ready with random stalls and an occasional long hold-off
   always @(negedge clock) begin : drive_rsp
      if (!reset) begin
         if (results_taken >= next_holdoff_at) begin
            holdoff_left = LongHoldoff;
            next_holdoff_at = next_holdoff_at + 700;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Check results, apply register writes and predict accepted ticks
   always @(posedge clock) begin : watch
      walk_out_type got;
      walk_out_type want;
      req_taken <= req_valid && req_ready;
      csr_taken <= csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_taken++;
            got.level = rsp_level;
            got.position = rsp_step_position;
            got.advanced = rsp_step_advanced;
            if (walk_results.size() == 0) begin
               bad_results++;
               if (bad_results <= 10) begin
                  $display("unexpected result: level %0d pos %0d adv %0d",
                           got.level, got.position, got.advanced);
               end
            end else begin
               want = walk_results.pop_front();
               if (got.level !== want.level || got.position !== want.position ||
                   got.advanced !== want.advanced) begin
                  bad_results++;
                  if (bad_results <= 10) begin
                     $display("result mismatch: level %0d/%0d pos %0d/%0d adv %0d/%0d",
                              want.level, got.level, want.position, got.position,
                              want.advanced, got.advanced);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rwls_pkg::CsrPeriod: cfg_period = csr_wdata[rwls_pkg::PeriodW-1:0];
               rwls_pkg::CsrAmount: cfg_amount = csr_wdata[rwls_pkg::AmountW-1:0];
               rwls_pkg::CsrLocked: cfg_locked = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            walk_results.push_back(walk_tick(req_random_draw));
         end
      end
   end

   initial begin : run
      int i;
      int ph;
      int n_ticks;
      logic [rwls_pkg::PeriodW-1:0] per;
      logic [rwls_pkg::AmountW-1:0] amt;
      logic lck;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_random_draw = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_taken = 1'b0;
      csr_taken = 1'b0;
      gap_left = 0;
      settle_left = DrainSettle;
      stall_left = 0;
      holdoff_left = 0;
      next_holdoff_at = 300;
      results_taken = 0;
      bad_results = 0;
      steady = 1'b0;
      steady_left = 60;
      for (i = 0; i < RingLen; i++) begin
         ring_steps[i] = '0;
      end
      for (i = 0; i < rwls_pkg::HistLen; i++) begin
         level_history[i] = '0;
      end
      tick_ctr = '0;
      hist_ctr = '0;
      step_idx = 0;
      cfg_period = rwls_pkg::PeriodReset;
      cfg_amount = rwls_pkg::AmountReset;
      cfg_locked = 1'b0;

      // Directed: reset defaults, draw extremes, clamp at both ends,
      // period zero, locked loop, zero and unit smoothing intervals
      plan_tick(6'd0);
      plan_tick(6'd63);
      plan_tick(6'h2A);
      plan_tick(6'h15);
      plan_setup(16'd0, 11'd0, 1'b0);
      plan_tick(6'd0);
      for (i = 0; i < 9; i++) begin
         plan_tick(6'd63);
      end
      plan_tick(6'd31);
      plan_tick(6'd32);
      plan_setup(16'd1, 11'd0, 1'b1);
      plan_tick(6'd0);
      plan_tick(6'd63);
      plan_setup(16'd1, 11'd1, 1'b0);
      for (i = 0; i < 3; i++) begin
         plan_tick(6'd0);
      end
      plan_setup(16'd1, 11'd2047, 1'b0);
      for (i = 0; i < 3; i++) begin
         plan_tick(6'd63);
      end

      // Random phases: a few fixed extreme settings, then random ones
      for (ph = 0; ph < 14; ph++) begin
         case (ph)
            0: begin per = 16'd1; amt = 11'd0; lck = 1'b0; end
            1: begin per = 16'd3; amt = 11'd2047; lck = 1'b0; end
            2: begin per = 16'd65535; amt = 11'd2047; lck = 1'b0; end
            3: begin per = 16'd2; amt = 11'd1; lck = 1'b1; end
            4: begin per = 16'd0; amt = 11'd1500; lck = 1'b1; end
            default: begin
               per = ($urandom_range(0, 9) < 4) ? 16'($urandom_range(0, 3))
                                                : 16'($urandom_range(4, 12));
               amt = ($urandom_range(0, 3) == 0) ? 11'd0 : 11'($urandom_range(1, 2047));
               lck = ($urandom_range(0, 3) == 0);
            end
         endcase
         plan_setup(per, amt, lck);
         n_ticks = $urandom_range(90, 130);
         for (i = 0; i < n_ticks; i++) begin
            plan_tick(6'($urandom));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the plan to drain and every result to come back
      while (tick_plan.size() != 0 || req_valid || csr_valid || walk_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (bad_results == 0 && walk_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
